### src/lss_pkg.sv
package lss_pkg;

   // Table size
   localparam int MaxStates = 64;
   localparam int TabAddrW  = $clog2(MaxStates);
   localparam int TabWidth  = 64;

   // Opcodes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_CMD    = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Command and active modes
   localparam logic [1:0] MD_OFF     = 2'd0;
   localparam logic [1:0] MD_STATIC  = 2'd1;
   localparam logic [1:0] MD_SCAN    = 2'd2;
   localparam logic [1:0] MD_INVALID = 2'd3;

   // Status codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_STATIC   = 3'd1;
   localparam logic [2:0] ST_SCANNING = 3'd2;
   localparam logic [2:0] ST_COMPLETE = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_MODE     = 2'd1;
   localparam logic [1:0] ERR_SCAN     = 2'd2;
   localparam logic [1:0] ERR_WATCHDOG = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_STATIC_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_MIN_DWELL      = 2'd1;
   localparam logic [1:0] REG_MAX_DWELL      = 2'd2;
   localparam logic [1:0] REG_MAX_REPEATS    = 2'd3;

   // Register reset values
   localparam logic [23:0] TimeoutReset    = 24'd2000000;
   localparam logic [20:0] MinDwellReset   = 21'd500;
   localparam logic [20:0] MaxDwellReset   = 21'd1000000;
   localparam logic [7:0]  MaxRepeatsReset = 8'd100;

   // Where the displayed words of a response come from
   typedef enum logic [1:0] {
      PIX_HOLD,
      PIX_ZERO,
      PIX_INPUT,
      PIX_TABLE
   } pix_sel_type;

   // Word in flight between the control stage and the output stage
   typedef struct packed {
      logic        valid;
      logic        show;
      pix_sel_type pix_sel;
      logic [31:0] pix_a;
      logic [31:0] pix_b;
      logic [2:0]  status;
      logic [1:0]  error;
      logic [5:0]  index;
      logic [7:0]  passes;
   } s1_type;

endpackage

### src/lss_req_if.sv
interface lss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [1:0]  mode;
   logic [31:0] pixel_a;
   logic [31:0] pixel_b;
   logic [5:0]  entry_index;
   logic [7:0]  entry_total;
   logic [7:0]  pass_total;
   logic [20:0] hold_ticks;

   modport source (
      output valid, opcode, mode, pixel_a, pixel_b, entry_index, entry_total,
             pass_total, hold_ticks,
      input  ready
   );
   modport sink (
      input  valid, opcode, mode, pixel_a, pixel_b, entry_index, entry_total,
             pass_total, hold_ticks,
      output ready
   );
endinterface

### src/lss_rsp_if.sv
interface lss_rsp_if;
   logic        valid;
   logic        ready;
   logic        show_frame;
   logic [31:0] pixel_a_out;
   logic [31:0] pixel_b_out;
   logic [2:0]  status;
   logic [1:0]  error_code;
   logic [5:0]  current_index;
   logic [7:0]  completed_passes;

   modport source (
      output valid, show_frame, pixel_a_out, pixel_b_out, status, error_code,
             current_index, completed_passes,
      input  ready
   );
   modport sink (
      input  valid, show_frame, pixel_a_out, pixel_b_out, status, error_code,
             current_index, completed_passes,
      output ready
   );
endinterface

### src/lss_ram.sv
module lss_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lss_ctrl.sv
module lss_ctrl
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // accepted word
   input  logic                accept,
   input  logic [1:0]          opcode,
   input  logic [1:0]          mode,
   input  logic [31:0]         pixel_a,
   input  logic [31:0]         pixel_b,
   input  logic [5:0]          entry_index,
   input  logic [7:0]          entry_total,
   input  logic [7:0]          pass_total,
   input  logic [20:0]         hold_ticks,
   // register writes
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_wdata,
   // table access
   output logic                tab_wr_en,
   output logic [TabAddrW-1:0] tab_wr_addr,
   output logic [TabAddrW-1:0] tab_rd_addr,
   // to output stage
   input  logic                advance,
   output s1_type              s1
);

   logic [23:0] timeout_ff, timeout_in;
   logic [20:0] min_dwell_ff, min_dwell_in;
   logic [20:0] max_dwell_ff, max_dwell_in;
   logic [7:0]  max_rep_ff, max_rep_in;

   logic [1:0]  act_mode_ff, act_mode_in;
   logic [6:0]  scan_len_ff, scan_len_in;
   logic [7:0]  pass_tgt_ff, pass_tgt_in;
   logic [20:0] dwell_rel_ff, dwell_rel_in;
   logic [20:0] dwell_left_ff, dwell_left_in;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  passes_ff, passes_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [2:0]  status_ff, status_in;
   logic [1:0]  err_ff, err_in;
   logic [5:0]  rep_idx_ff, rep_idx_in;
   s1_type      s1_ff, s1_in;

   logic        show_c;
   pix_sel_type sel_c;
   logic [6:0]  pos_next;
   logic [7:0]  passes_next;
   logic [23:0] elapsed_next;
   logic        scan_bad;

   // register port
   always_comb begin
      timeout_in   = timeout_ff;
      min_dwell_in = min_dwell_ff;
      max_dwell_in = max_dwell_ff;
      max_rep_in   = max_rep_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_STATIC_TIMEOUT: timeout_in   = csr_wdata;
            REG_MIN_DWELL:      min_dwell_in = csr_wdata[20:0];
            REG_MAX_DWELL:      max_dwell_in = csr_wdata[20:0];
            REG_MAX_REPEATS:    max_rep_in   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign pos_next     = {1'b0, pos_ff} + 7'd1;
   assign passes_next  = passes_ff + 8'd1;
   assign elapsed_next = (elapsed_ff != '1) ? elapsed_ff + 24'd1 : elapsed_ff;
   assign scan_bad = (entry_total == 8'd0) || (32'(entry_total) > MaxStates) ||
                     (pass_total == 8'd0) || (pass_total > max_rep_ff) ||
                     (hold_ticks < min_dwell_ff) || (hold_ticks > max_dwell_ff);

   always_comb begin
      act_mode_in   = act_mode_ff;
      scan_len_in   = scan_len_ff;
      pass_tgt_in   = pass_tgt_ff;
      dwell_rel_in  = dwell_rel_ff;
      dwell_left_in = dwell_left_ff;
      pos_in        = pos_ff;
      passes_in     = passes_ff;
      elapsed_in    = elapsed_ff;
      status_in     = status_ff;
      err_in        = err_ff;
      rep_idx_in    = rep_idx_ff;
      show_c        = 1'b0;
      sel_c         = PIX_HOLD;
      tab_wr_en     = 1'b0;
      tab_wr_addr   = TabAddrW'(entry_index);
      tab_rd_addr   = '0;

      if (accept) begin
         unique case (opcode)
            OP_TICK: begin
               if (act_mode_ff == MD_STATIC) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= timeout_ff) begin
                     show_c      = 1'b1;
                     sel_c       = PIX_ZERO;
                     act_mode_in = MD_OFF;
                     status_in   = ST_ERROR;
                     err_in      = ERR_WATCHDOG;
                  end
               end else if (act_mode_ff == MD_SCAN) begin
                  if (dwell_left_ff > 21'd1) begin
                     dwell_left_in = dwell_left_ff - 21'd1;
                  end else begin
                     dwell_left_in = dwell_rel_ff;
                     show_c        = 1'b1;
                     if (pos_next >= scan_len_ff) begin
                        // end of a pass
                        pos_in    = '0;
                        passes_in = passes_next;
                        if (passes_next >= pass_tgt_ff) begin
                           sel_c       = PIX_ZERO;
                           act_mode_in = MD_OFF;
                           status_in   = ST_COMPLETE;
                        end else begin
                           sel_c       = PIX_TABLE;
                           tab_rd_addr = '0;
                           rep_idx_in  = '0;
                        end
                     end else begin
                        pos_in      = pos_next[5:0];
                        sel_c       = PIX_TABLE;
                        tab_rd_addr = TabAddrW'(pos_next);
                        rep_idx_in  = pos_next[5:0];
                     end
                  end
               end
            end
            OP_CMD: begin
               err_in     = ERR_NONE;
               rep_idx_in = '0;
               passes_in  = '0;
               show_c     = 1'b1;
               unique case (mode)
                  MD_OFF: begin
                     sel_c       = PIX_ZERO;
                     act_mode_in = MD_OFF;
                     status_in   = ST_IDLE;
                  end
                  MD_STATIC: begin
                     sel_c       = PIX_INPUT;
                     elapsed_in  = '0;
                     act_mode_in = MD_STATIC;
                     status_in   = ST_STATIC;
                  end
                  MD_SCAN: begin
                     if (scan_bad) begin
                        sel_c       = PIX_ZERO;
                        act_mode_in = MD_OFF;
                        status_in   = ST_ERROR;
                        err_in      = ERR_SCAN;
                     end else begin
                        scan_len_in   = entry_total[6:0];
                        pass_tgt_in   = pass_total;
                        dwell_rel_in  = hold_ticks;
                        dwell_left_in = hold_ticks;
                        pos_in        = '0;
                        sel_c         = PIX_TABLE;
                        tab_rd_addr   = '0;
                        act_mode_in   = MD_SCAN;
                        status_in     = ST_SCANNING;
                     end
                  end
                  MD_INVALID: begin
                     sel_c       = PIX_ZERO;
                     act_mode_in = MD_OFF;
                     status_in   = ST_ERROR;
                     err_in      = ERR_MODE;
                  end
                  default: ;
               endcase
            end
            OP_LOAD: begin
               tab_wr_en = (32'(entry_index) < MaxStates);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (advance) begin
         s1_in.valid = 1'b0;
      end
      if (accept) begin
         s1_in.valid   = 1'b1;
         s1_in.show    = show_c;
         s1_in.pix_sel = sel_c;
         s1_in.pix_a   = pixel_a;
         s1_in.pix_b   = pixel_b;
         s1_in.status  = status_in;
         s1_in.error   = err_in;
         s1_in.index   = rep_idx_in;
         s1_in.passes  = passes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TimeoutReset;
         min_dwell_ff  <= MinDwellReset;
         max_dwell_ff  <= MaxDwellReset;
         max_rep_ff    <= MaxRepeatsReset;
         act_mode_ff   <= MD_OFF;
         scan_len_ff   <= '0;
         pass_tgt_ff   <= '0;
         dwell_rel_ff  <= '0;
         dwell_left_ff <= '0;
         pos_ff        <= '0;
         passes_ff     <= '0;
         elapsed_ff    <= '0;
         status_ff     <= ST_IDLE;
         err_ff        <= ERR_NONE;
         rep_idx_ff    <= '0;
         s1_ff.valid   <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         min_dwell_ff  <= min_dwell_in;
         max_dwell_ff  <= max_dwell_in;
         max_rep_ff    <= max_rep_in;
         act_mode_ff   <= act_mode_in;
         scan_len_ff   <= scan_len_in;
         pass_tgt_ff   <= pass_tgt_in;
         dwell_rel_ff  <= dwell_rel_in;
         dwell_left_ff <= dwell_left_in;
         pos_ff        <= pos_in;
         passes_ff     <= passes_in;
         elapsed_ff    <= elapsed_in;
         status_ff     <= status_in;
         err_ff        <= err_in;
         rep_idx_ff    <= rep_idx_in;
         s1_ff.valid   <= s1_in.valid;
      end
      s1_ff.show    <= s1_in.show;
      s1_ff.pix_sel <= s1_in.pix_sel;
      s1_ff.pix_a   <= s1_in.pix_a;
      s1_ff.pix_b   <= s1_in.pix_b;
      s1_ff.status  <= s1_in.status;
      s1_ff.error   <= s1_in.error;
      s1_ff.index   <= s1_in.index;
      s1_ff.passes  <= s1_in.passes;
   end

   assign s1 = s1_ff;

endmodule

### src/lss_out.sv
module lss_out
   import lss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  s1_type              s1,
   input  logic [TabWidth-1:0] tab_rd_data,
   output logic                advance,
   lss_rsp_if.source           rsp_if
);

   logic        shown_valid_ff;
   logic [31:0] shown_a_ff, shown_a_in;
   logic [31:0] shown_b_ff, shown_b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        show_ff;
   logic [31:0] pix_a_ff, pix_b_ff;
   logic [2:0]  status_ff;
   logic [1:0]  err_ff;
   logic [5:0]  index_ff;
   logic [7:0]  passes_ff;
   logic [31:0] sel_a, sel_b;

   assign advance = s1.valid && (!rsp_valid_ff || rsp_if.ready);

   // last shown words, zero out of reset
   always_comb begin
      case (s1.pix_sel)
         PIX_ZERO:  begin sel_a = '0;                 sel_b = '0;                  end
         PIX_INPUT: begin sel_a = s1.pix_a;           sel_b = s1.pix_b;            end
         PIX_TABLE: begin sel_a = tab_rd_data[31:0];  sel_b = tab_rd_data[63:32];  end
         default: begin
            sel_a = shown_valid_ff ? shown_a_ff : '0;
            sel_b = shown_valid_ff ? shown_b_ff : '0;
         end
      endcase
      shown_a_in = s1.show ? sel_a : (shown_valid_ff ? shown_a_ff : '0);
      shown_b_in = s1.show ? sel_b : (shown_valid_ff ? shown_b_ff : '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            shown_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         shown_a_ff <= shown_a_in;
         shown_b_ff <= shown_b_in;
         show_ff    <= s1.show;
         pix_a_ff   <= shown_a_in;
         pix_b_ff   <= shown_b_in;
         status_ff  <= s1.status;
         err_ff     <= s1.error;
         index_ff   <= s1.index;
         passes_ff  <= s1.passes;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.show_frame       = show_ff;
   assign rsp_if.pixel_a_out      = pix_a_ff;
   assign rsp_if.pixel_b_out      = pix_b_ff;
   assign rsp_if.status           = status_ff;
   assign rsp_if.error_code       = err_ff;
   assign rsp_if.current_index    = index_ff;
   assign rsp_if.completed_passes = passes_ff;

endmodule

### src/led_scan_sequencer.sv
// A taken word passes through stage one, then the response register, before its
// response can be taken. Throughput: one word per cycle while the response side keeps
// up; the scan table read starts as a word is taken and its registered data is used as
// the word leaves stage one, with the response register behind it.
// Reset (synchronous, active high) clears mode, counters, status and error, loads the
// register defaults and zeroes the shown words; scan table contents stay undefined.
module led_scan_sequencer
   import lss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lss_req_if.sink     req_if,
   lss_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // control stage <-> output stage
   s1_type                s1;
   logic                  advance;
   logic                  accept;

   // scan table port
   logic                  tab_wr_en;
   logic [TabAddrW-1:0]   tab_wr_addr;
   logic [TabAddrW-1:0]   tab_rd_addr;
   logic [TabWidth-1:0]   tab_rd_data;

   // Take a new word whenever the stage-one slot is empty or moving on; a stalled
   // response only holds off input once both stage one and the response are full.
   assign req_if.ready = !s1.valid || advance;
   assign accept       = req_if.valid && req_if.ready;

   // Scalar state update, register file and table address generation.
   lss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_if.opcode),
      .mode         (req_if.mode),
      .pixel_a      (req_if.pixel_a),
      .pixel_b      (req_if.pixel_b),
      .entry_index  (req_if.entry_index),
      .entry_total  (req_if.entry_total),
      .pass_total   (req_if.pass_total),
      .hold_ticks   (req_if.hold_ticks),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tab_wr_en    (tab_wr_en),
      .tab_wr_addr  (tab_wr_addr),
      .tab_rd_addr  (tab_rd_addr),
      .advance      (advance),
      .s1           (s1)
   );

   // Scan table: pixel b in the upper half, pixel a in the lower.
   // Read only on accept so the data holds while stage one stalls; a load
   // also starts a read (of entry zero), whose data the load word never uses.
   lss_ram #(
      .Width (TabWidth),
      .Depth (MaxStates)
   ) u_table (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data ({req_if.pixel_b, req_if.pixel_a}),
      .rd_en   (accept),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   // Shown-word tracking and response register.
   lss_out u_out (
      .clock       (clock),
      .reset       (reset),
      .s1          (s1),
      .tab_rd_data (tab_rd_data),
      .advance     (advance),
      .rsp_if      (rsp_if)
   );

   // Whenever the block is not static or scanning, the shown words are blank.
   a_off_blank : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != ST_STATIC && rsp_if.status != ST_SCANNING
      |-> rsp_if.pixel_a_out == '0 && rsp_if.pixel_b_out == '0)
      else $error("pixels not blank while off");

   // A nonzero error code comes only with error status.
   a_err_status : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.error_code != ERR_NONE |-> rsp_if.status == ST_ERROR)
      else $error("error code without error status");

   // A table load never asks for a frame.
   a_load_quiet : assert property (@(posedge clock) disable iff (reset)
      accept && req_if.opcode == OP_LOAD |=> s1.valid && !s1.show)
      else $error("load raised show_frame");

   // Stage one never moves on while the response register is full and stalled.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !advance)
      else $error("response overrun");

endmodule

### tb/sv/tb_led_scan_sequencer.sv
module tb_led_scan_sequencer
   import lss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One request word as the sender builds it
   typedef struct {
      logic [1:0]  opcode;
      logic [1:0]  mode;
      logic [31:0] pixel_a;
      logic [31:0] pixel_b;
      logic [5:0]  entry_index;
      logic [7:0]  entry_total;
      logic [7:0]  pass_total;
      logic [20:0] hold_ticks;
   } req_word_type;

   // One response word: what the LEDs should be given
   typedef struct {
      logic        show;
      logic [31:0] pix_a;
      logic [31:0] pix_b;
      logic [2:0]  status;
      logic [1:0]  error;
      logic [5:0]  index;
      logic [7:0]  passes;
   } frame_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   lss_req_if req_bus();
   lss_rsp_if rsp_bus();

   led_scan_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Sequencer prediction: own copy of the limits and of the light state
   // ------------------------------------------------------------------
   logic [23:0] cfg_timeout   = TimeoutReset;
   logic [20:0] cfg_min_dwell = MinDwellReset;
   logic [20:0] cfg_max_dwell = MaxDwellReset;
   logic [7:0]  cfg_max_rep   = MaxRepeatsReset;

   logic [1:0]  run_mode   = MD_OFF;
   logic [31:0] tab_a [MaxStates];
   logic [31:0] tab_b [MaxStates];
   logic [6:0]  scan_len   = '0;
   logic [7:0]  pass_goal  = '0;
   logic [20:0] dwell_set  = '0;
   logic [20:0] dwell_cnt  = '0;
   logic [5:0]  scan_pos   = '0;
   logic [7:0]  pass_cnt   = '0;
   logic [23:0] static_cnt = '0;
   logic [2:0]  cur_status = ST_IDLE;
   logic [1:0]  cur_error  = ERR_NONE;
   logic [5:0]  cur_index  = '0;
   logic [31:0] lit_a      = '0;
   logic [31:0] lit_b      = '0;

   frame_type pending_frames[$];
   int        mismatch_count = 0;

   // blank the pixels and drop to off with the given status and error
   function automatic void go_dark(input logic [2:0] st, input logic [1:0] er);
      lit_a      = '0;
      lit_b      = '0;
      run_mode   = MD_OFF;
      cur_status = st;
      cur_error  = er;
   endfunction

   // advance the light state by one word and give the frame it produces
   function automatic frame_type advance_sequencer(input req_word_type w);
      frame_type  f;
      logic [6:0] next_pos;
      logic       finished;
      f.show = 1'b0;
      case (w.opcode)
         OP_TICK: begin
            if (run_mode == MD_STATIC) begin
               if (static_cnt != 24'hFFFFFF)
                  static_cnt = static_cnt + 24'd1;
               if (static_cnt >= cfg_timeout) begin
                  go_dark(ST_ERROR, ERR_WATCHDOG);
                  f.show = 1'b1;
               end
            end else if (run_mode == MD_SCAN) begin
               if (dwell_cnt > 21'd1) begin
                  dwell_cnt = dwell_cnt - 21'd1;
               end else begin
                  // reload from the set value, never from the remainder: no drift
                  dwell_cnt = dwell_set;
                  next_pos  = {1'b0, scan_pos} + 7'd1;
                  finished  = 1'b0;
                  if (next_pos >= scan_len) begin
                     next_pos = '0;
                     pass_cnt = pass_cnt + 8'd1;
                     finished = (pass_cnt >= pass_goal);
                  end
                  scan_pos = next_pos[5:0];
                  f.show   = 1'b1;
                  if (finished) begin
                     // index keeps the last entry shown
                     go_dark(ST_COMPLETE, cur_error);
                  end else begin
                     lit_a     = tab_a[scan_pos];
                     lit_b     = tab_b[scan_pos];
                     cur_index = scan_pos;
                  end
               end
            end
         end
         OP_CMD: begin
            cur_error = ERR_NONE;
            cur_index = '0;
            pass_cnt  = '0;
            f.show    = 1'b1;
            case (w.mode)
               MD_OFF: go_dark(ST_IDLE, ERR_NONE);
               MD_STATIC: begin
                  lit_a      = w.pixel_a;
                  lit_b      = w.pixel_b;
                  static_cnt = '0;
                  run_mode   = MD_STATIC;
                  cur_status = ST_STATIC;
               end
               MD_SCAN: begin
                  if (w.entry_total == 8'd0 || 32'(w.entry_total) > MaxStates ||
                      w.pass_total == 8'd0 || w.pass_total > cfg_max_rep ||
                      w.hold_ticks < cfg_min_dwell || w.hold_ticks > cfg_max_dwell) begin
                     go_dark(ST_ERROR, ERR_SCAN);
                  end else begin
                     scan_len   = w.entry_total[6:0];
                     pass_goal  = w.pass_total;
                     dwell_set  = w.hold_ticks;
                     dwell_cnt  = w.hold_ticks;
                     scan_pos   = '0;
                     lit_a      = tab_a[0];
                     lit_b      = tab_b[0];
                     run_mode   = MD_SCAN;
                     cur_status = ST_SCANNING;
                  end
               end
               default: go_dark(ST_ERROR, ERR_MODE);
            endcase
         end
         OP_LOAD: begin
            // never raises show_frame, even mid-scan
            tab_a[w.entry_index] = w.pixel_a;
            tab_b[w.entry_index] = w.pixel_b;
         end
         default: ;  // unused opcode: outputs repeat, no frame
      endcase
      f.pix_a  = lit_a;
      f.pix_b  = lit_b;
      f.status = cur_status;
      f.error  = cur_error;
      f.index  = cur_index;
      f.passes = pass_cnt;
      return f;
   endfunction

   // ------------------------------------------------------------------
   // Response side: stall pattern and frame checking
   // ------------------------------------------------------------------
   logic [15:0] stall_mask  = 16'hFFFF;
   logic [6:0]  stall_count = '0;

   function automatic logic [15:0] pick_stall_mask();
      logic [15:0] m;
      case ($urandom_range(0, 3))
         0:       m = 16'hFFFF;                              // no stalls at all
         1:       m = 16'($urandom);
         2:       m = 16'($urandom | $urandom);              // light stalling
         default: m = 16'($urandom & $urandom) | 16'h0001;   // heavy stalling
      endcase
      return m;
   endfunction

   function automatic void match_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.ready && rsp_bus.valid !== 1'b0) begin
         if (pending_frames.size() == 0) begin
            $error("response word arrived with nothing pending");
            mismatch_count++;
         end else begin
            frame_type want;
            want = pending_frames.pop_front();
            match_field("show_frame",       32'(want.show),   32'(rsp_bus.show_frame));
            match_field("pixel_a_out",      want.pix_a,       rsp_bus.pixel_a_out);
            match_field("pixel_b_out",      want.pix_b,       rsp_bus.pixel_b_out);
            match_field("status",           32'(want.status), 32'(rsp_bus.status));
            match_field("error_code",       32'(want.error),  32'(rsp_bus.error_code));
            match_field("current_index",    32'(want.index),  32'(rsp_bus.current_index));
            match_field("completed_passes", 32'(want.passes),
                        32'(rsp_bus.completed_passes));
         end
      end
      // new stall pattern each time the 7-bit stall counter wraps, rotated in between
      stall_count <= stall_count + 7'd1;
      if (stall_count == '0)
         stall_mask <= pick_stall_mask();
      else
         stall_mask <= {stall_mask[0], stall_mask[15:1]};
      rsp_bus.ready <= stall_mask[0];
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   int burst_left     = 0;
   int sender_gap_max = 6;

   // every field random; callers override what matters
   function automatic req_word_type scrambled_word();
      req_word_type w;
      w.opcode      = 2'($urandom);
      w.mode        = 2'($urandom);
      w.pixel_a     = $urandom;
      w.pixel_b     = $urandom;
      w.entry_index = 6'($urandom);
      w.entry_total = 8'($urandom);
      w.pass_total  = 8'($urandom);
      w.hold_ticks  = 21'($urandom);
      return w;
   endfunction

   function automatic req_word_type tick_word();
      req_word_type w = scrambled_word();
      w.opcode = OP_TICK;
      return w;
   endfunction

   function automatic req_word_type command_word(input logic [1:0] mode,
                                                 input logic [31:0] pa,
                                                 input logic [31:0] pb);
      req_word_type w = scrambled_word();
      w.opcode  = OP_CMD;
      w.mode    = mode;
      w.pixel_a = pa;
      w.pixel_b = pb;
      return w;
   endfunction

   function automatic req_word_type scan_word(input logic [7:0] cnt, input logic [7:0] rep,
                                              input logic [20:0] dwell);
      req_word_type w = command_word(MD_SCAN, $urandom, $urandom);
      w.entry_total = cnt;
      w.pass_total  = rep;
      w.hold_ticks  = dwell;
      return w;
   endfunction

   function automatic req_word_type load_word(input logic [5:0] idx,
                                              input logic [31:0] pa,
                                              input logic [31:0] pb);
      req_word_type w = scrambled_word();
      w.opcode      = OP_LOAD;
      w.entry_index = idx;
      w.pixel_a     = pa;
      w.pixel_b     = pb;
      return w;
   endfunction

   // Offer one word, in bursts with random gaps; predict once it is taken.
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = (sender_gap_max == 0 || $urandom_range(0, 3) == 0) ?
               0 : $urandom_range(1, sender_gap_max);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= w.opcode;
      req_bus.mode        <= w.mode;
      req_bus.pixel_a     <= w.pixel_a;
      req_bus.pixel_b     <= w.pixel_b;
      req_bus.entry_index <= w.entry_index;
      req_bus.entry_total <= w.entry_total;
      req_bus.pass_total  <= w.pass_total;
      req_bus.hold_ticks  <= w.hold_ticks;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_frames.push_back(advance_sequencer(w));
   endtask

   // Hold off until every expected word is back, plus a little for the pipe.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four limit registers back to back while the block is idle.
   task automatic program_limits(input logic [23:0] tmo, input logic [20:0] mn,
                                 input logic [20:0] mx, input logic [7:0] reps);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= REG_STATIC_TIMEOUT;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_index <= REG_MIN_DWELL;
      csr_wdata <= {3'b000, mn};
      @(posedge clock);
      csr_index <= REG_MAX_DWELL;
      csr_wdata <= {3'b000, mx};
      @(posedge clock);
      csr_index <= REG_MAX_REPEATS;
      csr_wdata <= {16'h0000, reps};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_timeout   = tmo;
      cfg_min_dwell = mn;
      cfg_max_dwell = mx;
      cfg_max_rep   = reps;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Default limits: every command kind, each scan check failing on its own,
   // the unused opcode, and scans accepted right at the limits.
   task automatic test_commands_at_reset_limits();
      send_word(tick_word());                       // tick while off: nothing
      begin
         req_word_type w = scrambled_word();
         w.opcode = OP_UNUSED;                      // unused opcode is ignored
         send_word(w);
      end
      send_word(load_word(6'd0, 32'hFFFFFFFF, 32'h00000000));
      send_word(load_word(6'd63, 32'h00000000, 32'hFFFFFFFF));
      send_word(command_word(MD_STATIC, 32'hFFFFFFFF, 32'h00000000));
      send_word(tick_word());
      send_word(command_word(MD_INVALID, $urandom, $urandom));
      send_word(command_word(MD_OFF, $urandom, $urandom));
      // scan checks, one failing at a time
      send_word(scan_word(8'd0, 8'd1, 21'd500));
      send_word(scan_word(8'd65, 8'd1, 21'd500));
      send_word(scan_word(8'd255, 8'd1, 21'd500));
      send_word(scan_word(8'd1, 8'd0, 21'd500));
      send_word(scan_word(8'd1, 8'd101, 21'd500));
      send_word(scan_word(8'd1, 8'd1, 21'd499));
      send_word(scan_word(8'd1, 8'd1, 21'd1000001));
      send_word(scan_word(8'd1, 8'd1, 21'h1FFFFF));
      // accepted at both limits; long dwell, so ticks only count down
      send_word(scan_word(8'd1, 8'd100, 21'd500));
      repeat (2) send_word(tick_word());
      send_word(scan_word(8'd1, 8'd1, 21'd1000000));
      send_word(tick_word());
      send_word(command_word(MD_OFF, $urandom, $urandom));
   endtask

   // Static watchdog, including a zero timeout that fires on the first tick.
   task automatic test_static_watchdog();
      program_limits(24'd3, 21'd0, 21'd4, 8'd255);
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      repeat (2) send_word(tick_word());
      send_word(load_word(6'd5, $urandom, $urandom)); // load does not feed the watchdog
      repeat (2) send_word(tick_word());               // fires on the third tick
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      send_word(tick_word());
      send_word(command_word(MD_OFF, $urandom, $urandom));
      program_limits(24'd0, 21'd0, 21'd4, 8'd255);
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      repeat (2) send_word(tick_word());
   endtask

   // Stepping, pass counting, completion, loads mid-scan and interruption.
   task automatic test_scan_sequencing();
      program_limits(24'hFFFFFF, 21'd0, 21'd4, 8'd255);
      for (int i = 0; i < 4; i++)
         send_word(load_word(i[5:0], $urandom, $urandom));
      // zero dwell holds each entry for one tick
      send_word(scan_word(8'd3, 8'd2, 21'd0));
      repeat (7) send_word(tick_word());
      // reload entry 1 before it is reached
      send_word(scan_word(8'd2, 8'd1, 21'd3));
      repeat (2) send_word(tick_word());
      send_word(load_word(6'd1, $urandom, $urandom));
      repeat (5) send_word(tick_word());
      // a new command cuts a running scan short
      send_word(scan_word(8'd4, 8'd3, 21'd2));
      repeat (5) send_word(tick_word());
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      send_word(tick_word());
      send_word(command_word(MD_OFF, $urandom, $urandom));
      // most passes the count can hold
      send_word(scan_word(8'd1, 8'd255, 21'd1));
      repeat (256) send_word(tick_word());
      send_word(command_word(MD_OFF, $urandom, $urandom));
   endtask

   // Whole table loaded, then one pass over all of it.
   task automatic test_full_table();
      for (int i = 0; i < MaxStates; i++)
         send_word(load_word(i[5:0], $urandom, $urandom));
      send_word(scan_word(8'd64, 8'd1, 21'd1));
      repeat (66) send_word(tick_word());
   endtask

   // Limit registers at their extremes.
   task automatic test_limit_extremes();
      program_limits(24'd1, 21'h1FFFFF, 21'h1FFFFF, 8'd1);
      send_word(scan_word(8'd2, 8'd1, 21'h1FFFFF));
      repeat (2) send_word(tick_word());
      send_word(scan_word(8'd2, 8'd1, 21'h1FFFFE));
      send_word(scan_word(8'd2, 8'd2, 21'h1FFFFF));
      send_word(scan_word(8'd64, 8'd1, 21'h1FFFFF));
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      repeat (2) send_word(tick_word());
      program_limits(24'hFFFFFF, 21'd0, 21'd0, 8'd1);
      send_word(scan_word(8'd2, 8'd1, 21'd0));
      repeat (3) send_word(tick_word());
      send_word(scan_word(8'd2, 8'd1, 21'd1));
      send_word(command_word(MD_STATIC, $urandom, $urandom));
      repeat (3) send_word(tick_word());
   endtask

   // Mostly ticks, then loads and commands with random content; scans mostly well-formed, the rest broken or noise.
   function automatic req_word_type random_word();
      req_word_type w = scrambled_word();
      int           r = $urandom_range(0, 99);
      int           m;
      int           rep_top;
      if (r < 62) begin
         w.opcode = OP_TICK;
      end else if (r < 78) begin
         w.opcode = OP_LOAD;
      end else if (r < 97) begin
         w.opcode = OP_CMD;
         m = $urandom_range(0, 19);
         w.mode = (m < 11) ? MD_SCAN : (m < 15) ? MD_STATIC :
                  (m < 18) ? MD_OFF : MD_INVALID;
         if (w.mode == MD_SCAN) begin
            rep_top = (cfg_max_rep > 8'd4) ? 4 : 32'(cfg_max_rep);
            w.entry_total = ($urandom_range(0, 9) == 0) ? 8'(MaxStates) :
                            8'($urandom_range(1, 6));
            w.pass_total  = 8'($urandom_range(1, rep_top));
            w.hold_ticks  = cfg_min_dwell +
                            21'($urandom_range(0, 32'(cfg_max_dwell - cfg_min_dwell)));
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 4))
                  0: w.entry_total = 8'd0;
                  1: w.entry_total = 8'($urandom_range(MaxStates + 1, 255));
                  2: w.pass_total = (cfg_max_rep == 8'd255) ? 8'd0 : cfg_max_rep + 8'd1;
                  3: w.hold_ticks = (cfg_min_dwell != '0) ? cfg_min_dwell - 21'd1 :
                                                            cfg_max_dwell + 21'd1;
                  default: begin
                     w.entry_total = 8'($urandom);
                     w.pass_total  = 8'($urandom);
                     w.hold_ticks  = 21'($urandom);
                  end
               endcase
            end
         end
      end else begin
         w.opcode = OP_UNUSED;
      end
      return w;
   endfunction

   task automatic test_random_traffic();
      logic [23:0] tmo;
      logic [20:0] mn;
      logic [20:0] mx;
      logic [7:0]  reps;
      for (int phase = 0; phase < 4; phase++) begin
         tmo  = (phase == 1) ? 24'd0 : 24'($urandom_range(1, 60));
         mn   = (phase == 3) ? 21'd0 : 21'($urandom_range(0, 3));
         mx   = (phase == 3) ? 21'd0 : mn + 21'($urandom_range(0, 4));
         reps = (phase == 2) ? 8'd255 : 8'($urandom_range(1, 4));
         program_limits(tmo, mn, mx, reps);
         sender_gap_max = (phase == 1) ? 0 : 6;   // one phase runs flat out
         repeat (232) begin
            send_word(random_word());
            if ($urandom_range(0, 199) == 0)
               wait_idle();                      // let everything drain now and then
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= '0;
      req_bus.mode        <= '0;
      req_bus.pixel_a     <= '0;
      req_bus.pixel_b     <= '0;
      req_bus.entry_index <= '0;
      req_bus.entry_total <= '0;
      req_bus.pass_total  <= '0;
      req_bus.hold_ticks  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_commands_at_reset_limits();
      test_static_watchdog();
      test_scan_sequencing();
      test_full_table();
      test_limit_extremes();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      for (int n = 0; n < 5000 && pending_frames.size() != 0; n++)
         @(posedge clock);
      if (pending_frames.size() != 0) begin
         $error("%0d expected words never arrived", pending_frames.size());
         mismatch_count++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
src/lss_pkg.sv
src/lss_req_if.sv
src/lss_rsp_if.sv
src/lss_ram.sv
src/lss_ctrl.sv
src/lss_out.sv
src/led_scan_sequencer.sv
tb/sv/tb_led_scan_sequencer.sv
